// ----- rtl/drp_pkg.sv -----
`default_nettype none

package drp_pkg;

    // record kinds carried in bits 6:4 of a record's first byte
    localparam logic [2:0] KIND_NONE_A   = 3'd0;
    localparam logic [2:0] KIND_SINGLE_A = 3'd1;
    localparam logic [2:0] KIND_NONE_B   = 3'd2;
    localparam logic [2:0] KIND_SINGLE_B = 3'd3;
    localparam logic [2:0] KIND_SINGLE_C = 3'd4;
    localparam logic [2:0] KIND_DOUBLE   = 3'd5;
    localparam logic [2:0] KIND_NONE_C   = 3'd6;
    localparam logic [2:0] KIND_NONE_D   = 3'd7;

    localparam int          DATA_W      = 8;
    localparam int          SUBS_W      = 4;
    localparam int          TARGET_W    = 9;
    localparam int          COUNT_W     = 8;
    localparam int          POS_W       = 3;
    localparam logic [8:0]  COUNT_CAP   = 9'h1FF;
    localparam logic [7:0]  MAX_RESET   = 8'hFF;
    localparam int          SLOTS       = 3;
    localparam int          FIFO_DEPTH  = 4;
    localparam int          FIFO_AW     = 2;
    localparam int          FIFO_CW     = 3;

    // one result item
    typedef struct packed {
        logic [TARGET_W-1:0] target_index;
        logic                target_valid;
        logic                done_res;
        logic [COUNT_W-1:0]  target_count;
    } drp_result_t;

    // results produced by one accepted byte: first target, second target, done
    typedef struct packed {
        logic [SLOTS-1:0]              en;
        drp_result_t [SLOTS-1:0]       slot;
    } drp_push_t;

    // record length in bytes for each kind
    function automatic logic [POS_W-1:0] kind_length(input logic [2:0] kind);
        logic [POS_W-1:0] len;
        case (kind)
            KIND_NONE_A:   len = 3'd1;
            KIND_SINGLE_A: len = 3'd3;
            KIND_NONE_B:   len = 3'd1;
            KIND_SINGLE_B: len = 3'd3;
            KIND_SINGLE_C: len = 3'd3;
            KIND_DOUBLE:   len = 3'd5;
            KIND_NONE_C:   len = 3'd1;
            KIND_NONE_D:   len = 3'd1;
            default:       len = 3'd1;
        endcase
        return len;
    endfunction

    // kinds that carry at least one target
    function automatic logic kind_has_target(input logic [2:0] kind);
        return (kind == KIND_SINGLE_A) || (kind == KIND_SINGLE_B) ||
               (kind == KIND_SINGLE_C) || (kind == KIND_DOUBLE);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/drp_core.sv -----
`default_nettype none

module drp_core #(
    parameter int GUARD_RECORDS = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_xfer,
    input  wire logic [drp_pkg::DATA_W-1:0]    data_byte,
    input  wire logic                          start_req,
    input  wire logic [drp_pkg::SUBS_W-1:0]    sub_sequences,
    input  wire logic                          end_of_image,
    input  wire logic                          cfg_wr_en,
    input  wire logic [drp_pkg::COUNT_W-1:0]   cfg_wr_data,
    output drp_pkg::drp_push_t                 push
);

    localparam int REC_W = $clog2(GUARD_RECORDS + 1);

    logic                          busy_reg, busy_next;
    logic [drp_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [2:0]                    kind_reg, kind_next;
    logic                          close_reg, close_next;
    logic [drp_pkg::DATA_W-1:0]    rb_reg [4];
    logic                          rb_we;
    logic [1:0]                    rb_sel;
    logic [drp_pkg::SUBS_W-1:0]    seq_reg, seq_next;
    logic [REC_W-1:0]              rec_reg, rec_next;
    logic [8:0]                    cnt_reg, cnt_next;
    logic [drp_pkg::COUNT_W-1:0]   max_reg;

    // parse one byte
    always_comb begin
        logic                          busy_e;
        logic [drp_pkg::SUBS_W-1:0]    seq_e;
        logic [drp_pkg::SUBS_W-1:0]    seq_dec;
        logic [REC_W-1:0]              rec_e;
        logic [REC_W:0]                rec_inc;
        logic [8:0]                    cnt_e;
        logic [8:0]                    cnt_1;
        logic [drp_pkg::POS_W-1:0]     pos_e;
        logic [drp_pkg::POS_W-1:0]     pos_inc;
        logic [2:0]                    kind_e;
        logic                          close_e;
        logic [drp_pkg::DATA_W-1:0]    hi1;
        logic                          finish;
        logic                          emit1;
        logic                          emit2;

        busy_next  = busy_reg;
        pos_next   = pos_reg;
        kind_next  = kind_reg;
        close_next = close_reg;
        seq_next   = seq_reg;
        rec_next   = rec_reg;
        cnt_next   = cnt_reg;
        rb_we      = 1'b0;
        rb_sel     = 2'd0;
        finish     = 1'b0;
        emit1      = 1'b0;
        emit2      = 1'b0;

        busy_e  = busy_reg;
        seq_e   = seq_reg;
        rec_e   = rec_reg;
        cnt_e   = cnt_reg;
        pos_e   = pos_reg;
        cnt_1   = cnt_reg;
        seq_dec = seq_reg;
        rec_inc = '0;
        pos_inc = '0;

        // a start clears the entry state
        if (start_req) begin
            busy_e = 1'b1;
            seq_e  = sub_sequences;
            rec_e  = '0;
            cnt_e  = '0;
            pos_e  = '0;
        end

        kind_e  = (pos_e == '0) ? data_byte[6:4] : kind_reg;
        close_e = (pos_e == '0) ? data_byte[7] : close_reg;
        hi1     = (pos_e == 3'd2) ? data_byte : rb_reg[1];

        if (in_xfer) begin
            busy_next = busy_e;
            seq_next  = seq_e;
            rec_next  = rec_e;
            cnt_next  = cnt_e;
            pos_next  = pos_e;

            if (start_req && (sub_sequences == '0)) begin
                // empty entry closes at once
                finish = 1'b1;
            end else if (busy_e) begin
                kind_next  = kind_e;
                close_next = close_e;
                rb_we      = (pos_e != '0);
                rb_sel     = 2'(pos_e - 3'd1);
                pos_inc    = pos_e + 3'd1;
                pos_next   = pos_inc;

                if (pos_inc >= drp_pkg::kind_length(kind_e)) begin
                    // record complete: emit and count its targets
                    if (drp_pkg::kind_has_target(kind_e)) begin
                        emit1 = (cnt_e < {1'b0, max_reg});
                        cnt_1 = (cnt_e < drp_pkg::COUNT_CAP) ? cnt_e + 9'd1 : cnt_e;
                    end else begin
                        cnt_1 = cnt_e;
                    end
                    cnt_next = cnt_1;
                    if (kind_e == drp_pkg::KIND_DOUBLE) begin
                        emit2 = (cnt_1 < {1'b0, max_reg});
                        cnt_next = (cnt_1 < drp_pkg::COUNT_CAP) ? cnt_1 + 9'd1 : cnt_1;
                    end
                    pos_next = '0;
                    rec_inc  = {1'b0, rec_e} + 1'b1;
                    rec_next = rec_inc[REC_W-1:0];
                    if (close_e || (rec_inc >= (REC_W+1)'(GUARD_RECORDS))) begin
                        rec_next = '0;
                        seq_dec  = seq_e - 4'd1;
                        seq_next = seq_dec;
                        if (seq_dec == '0) begin
                            finish = 1'b1;
                        end
                    end
                end
                if (end_of_image) begin
                    finish = 1'b1;
                end
            end

            if (finish) begin
                busy_next = 1'b0;
                pos_next  = '0;
            end
        end

        // result slots
        push.en   = {finish, emit2, emit1};
        push.slot[0].target_index = {hi1[0], rb_reg[0]};
        push.slot[0].target_valid = 1'b1;
        push.slot[0].done_res     = 1'b0;
        push.slot[0].target_count = '0;
        push.slot[1].target_index = {data_byte[0], rb_reg[2]};
        push.slot[1].target_valid = 1'b1;
        push.slot[1].done_res     = 1'b0;
        push.slot[1].target_count = '0;
        push.slot[2].target_index = '0;
        push.slot[2].target_valid = 1'b0;
        push.slot[2].done_res     = 1'b1;
        push.slot[2].target_count = (cnt_next > {1'b0, max_reg}) ? max_reg :
                                    cnt_next[drp_pkg::COUNT_W-1:0];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            pos_reg   <= '0;
            kind_reg  <= '0;
            close_reg <= 1'b0;
            seq_reg   <= '0;
            rec_reg   <= '0;
            cnt_reg   <= '0;
            max_reg   <= drp_pkg::MAX_RESET;
        end else begin
            busy_reg  <= busy_next;
            pos_reg   <= pos_next;
            kind_reg  <= kind_next;
            close_reg <= close_next;
            seq_reg   <= seq_next;
            rec_reg   <= rec_next;
            cnt_reg   <= cnt_next;
            if (cfg_wr_en) begin
                max_reg <= cfg_wr_data;
            end
        end
    end

    // record payload bytes
    always_ff @(posedge aclk) begin
        if (rb_we) begin
            rb_reg[rb_sel] <= data_byte;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/drp_result_fifo.sv -----
`default_nettype none

module drp_result_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire drp_pkg::drp_push_t push,
    output logic               room,
    output logic               out_valid,
    input  wire logic          out_ready,
    output drp_pkg::drp_result_t out_data
);

    drp_pkg::drp_result_t            mem [drp_pkg::FIFO_DEPTH];
    logic [drp_pkg::FIFO_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [drp_pkg::FIFO_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [drp_pkg::FIFO_CW-1:0]     count_reg, count_next;
    logic [drp_pkg::FIFO_AW-1:0]     off [drp_pkg::SLOTS];
    logic [drp_pkg::FIFO_CW-1:0]     push_num;
    logic                            pop;

    // slot offsets so that results land in consecutive entries
    always_comb begin
        off[0]   = '0;
        off[1]   = drp_pkg::FIFO_AW'(push.en[0]);
        off[2]   = drp_pkg::FIFO_AW'(push.en[0]) + drp_pkg::FIFO_AW'(push.en[1]);
        push_num = drp_pkg::FIFO_CW'(push.en[0]) + drp_pkg::FIFO_CW'(push.en[1])
                 + drp_pkg::FIFO_CW'(push.en[2]);
    end

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rd_ptr_reg];
    // room for the worst case of three results from the next byte
    assign room      = (count_reg <= drp_pkg::FIFO_CW'(1));

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg + push_num[drp_pkg::FIFO_AW-1:0];
        rd_ptr_next = rd_ptr_reg + drp_pkg::FIFO_AW'(pop);
        count_next  = count_reg + push_num - drp_pkg::FIFO_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry writes
    always_ff @(posedge aclk) begin
        for (int i = 0; i < drp_pkg::SLOTS; i++) begin
            if (push.en[i]) begin
                mem[wr_ptr_reg + off[i]] <= push.slot[i];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/diphone_record_parser_unit.sv -----
`default_nettype none

// Diphone record parser: takes the record bytes of one diphone entry and
// expands them into 9-bit acoustic target indices, closing each entry with a
// done transfer (m_tlast high) that carries the target count saturated at
// max_targets. Each byte is parsed in the cycle it is accepted; its 0 to 3
// results enter a four-entry result queue and are offered from it. s_tready
// is high while at most one result is queued: with m_tready high, bytes
// yielding one result or none flow at one per cycle, and a byte that yields
// two or three results holds input off until the queue has drained to one
// entry, as the queue delivers one result per cycle. max_targets is written
// through cfg_wr_en / cfg_wr_data, by the user only while idle: not enforced.

module diphone_record_parser_unit #(
    parameter int GUARD_RECORDS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // config: max_targets
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // data_byte[7:0], sub_sequences[11:8], zero
    input  wire logic        s_tuser,   // start_req
    input  wire logic        s_tlast,   // end_of_image
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // target_index[8:0], target_count[16:9], zero
    output logic             m_tuser,   // target_valid
    output logic             m_tlast    // done_res
);

    drp_pkg::drp_push_t   push;
    drp_pkg::drp_result_t res;
    logic                 in_xfer;

    assign in_xfer = s_tvalid && s_tready;

    // byte parser and entry state
    drp_core #(
        .GUARD_RECORDS(GUARD_RECORDS)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_xfer       (in_xfer),
        .data_byte     (s_tdata[7:0]),
        .start_req     (s_tuser),
        .sub_sequences (s_tdata[11:8]),
        .end_of_image  (s_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .push          (push)
    );

    // result queue
    drp_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    // pack the result transfer
    assign m_tdata = {7'd0, res.target_count, res.target_index};
    assign m_tuser = res.target_valid;
    assign m_tlast = res.done_res;

endmodule

`default_nettype wire
